[hw/rtl/stb_pkg.sv]
package stb_pkg;

    // bank geometry
    localparam int TIMER_COUNT = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int WALK_W      = $clog2(TIMER_COUNT + 1);

    // transaction field widths
    localparam int OP_W     = 3;
    localparam int ID_W     = 3;
    localparam int PERIOD_W = 32;
    localparam int TIME_W   = 31;
    localparam int ID_EXT_W = (IDX_W > ID_W) ? IDX_W : ID_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_ONCE      = 3'd1;
    localparam logic [OP_W-1:0] OP_AUTO      = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK     = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_TIME = 3'd5;
    localparam logic [OP_W-1:0] OP_ELAPSED   = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED    = 3'd7;

    // run-time counter wraps to zero instead of reaching all ones
    localparam logic [TIME_W-1:0] UPTIME_WRAP = {TIME_W{1'b1}};

    // strobe phase
    localparam int             PHASE_W      = 3;
    localparam logic [PHASE_W-1:0] STROBE_EVERY = 3'd5;

    // write command into the timer bank, one entry per cycle
    typedef struct packed {
        logic                   we_rem;
        logic [COUNT_WIDTH-1:0] rem;
        logic                   we_rel;
        logic [COUNT_WIDTH-1:0] rel;
        logic                   we_flag;
        logic                   flag;
        logic                   we_mode;
        logic                   mode;
        logic [IDX_W-1:0]       addr;
    } t_bank_wr;

    // registered read data of one bank entry
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] rem;
        logic [COUNT_WIDTH-1:0] rel;
        logic                   flag;
        logic                   mode;
    } t_bank_rd;

endpackage

[hw/rtl/stb_bank.sv]
module stb_bank import stb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_bank_wr         i_wr,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_bank_rd         o_rd
);

    // counter and period memories, zero until first written
    logic [COUNT_WIDTH-1:0] r_rem_mem [TIMER_COUNT];
    logic [COUNT_WIDTH-1:0] r_rel_mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] r_rem_vld;
    logic [TIMER_COUNT-1:0] r_rel_vld;
    logic [TIMER_COUNT-1:0] r_flag;
    logic [TIMER_COUNT-1:0] r_mode;
    t_bank_rd               r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_rem) begin
            r_rem_mem[i_wr.addr] <= i_wr.rem;
        end
        if (i_wr.we_rel) begin
            r_rel_mem[i_wr.addr] <= i_wr.rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_vld <= '0;
            r_rel_vld <= '0;
            r_flag    <= '0;
            r_mode    <= '0;
        end else begin
            if (i_wr.we_rem) begin
                r_rem_vld[i_wr.addr] <= 1'b1;
            end
            if (i_wr.we_rel) begin
                r_rel_vld[i_wr.addr] <= 1'b1;
            end
            if (i_wr.we_flag) begin
                r_flag[i_wr.addr] <= i_wr.flag;
            end
            if (i_wr.we_mode) begin
                r_mode[i_wr.addr] <= i_wr.mode;
            end
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd.rem  <= r_rem_vld[i_rd_addr] ? r_rem_mem[i_rd_addr] : '0;
            r_rd.rel  <= r_rel_vld[i_rd_addr] ? r_rel_mem[i_rd_addr] : '0;
            r_rd.flag <= r_flag[i_rd_addr];
            r_rd.mode <= r_mode[i_rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

[hw/rtl/soft_timer_bank.sv]
// channel  | valid    | stall     | payload
// ---------+----------+-----------+-----------------------------------------------
// request  | i_valid  | o_stall   | i_operation i_timer_id i_period i_last_time
// result   | o_valid  | i_stall   | o_expired o_run_time o_elapsed o_half_second
//
// a tick walks every timer through one shared decrementer: one bank read issued per cycle,
// the write-back of the previous entry overlapped
// a check reads its flag in a state of its own; load, stop, read-time and elapsed go straight to done
// one request at a time: o_stall is high from acceptance until the result is registered
// the result register frees the request side while a finished result waits on i_stall
// synchronous active-low reset clears all timers, flags, modes and the run-time counter
module soft_timer_bank import stb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [ID_W-1:0]     i_timer_id,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic [TIME_W-1:0]   i_last_time,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_expired,
    output logic [TIME_W-1:0]   o_run_time,
    output logic [TIME_W-1:0]   o_elapsed,
    output logic                o_half_second
);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]          r_state,  n_state;
    logic [OP_W-1:0]     r_op,     n_op;
    logic [TIME_W-1:0]   r_last,   n_last;
    logic [IDX_W-1:0]    r_cid,    n_cid;
    logic                r_id_ok,  n_id_ok;
    logic                r_exp,    n_exp;
    logic                r_hs,     n_hs;
    logic [WALK_W-1:0]   r_idx,    n_idx;
    logic                r_pend,   n_pend;
    logic [IDX_W-1:0]    r_widx,   n_widx;
    logic [TIME_W-1:0]   r_uptime, n_uptime;
    logic [PHASE_W-1:0]  r_phase,  n_phase;
    logic                r_out_vld, n_out_vld;

    // result register, payload only
    logic                r_o_exp;
    logic [TIME_W-1:0]   r_o_run;
    logic [TIME_W-1:0]   r_o_el;
    logic                r_o_hs;

    t_bank_wr            w_wr;
    t_bank_rd            w_rd;
    logic                w_rd_en;
    logic [IDX_W-1:0]    w_rd_addr;

    logic [ID_EXT_W-1:0]    w_id_ext;
    logic [IDX_W-1:0]       w_id;
    logic                   w_id_ok;
    logic [COUNT_WIDTH-1:0] w_dec;
    logic [TIME_W-1:0]      w_up_inc;
    logic [PHASE_W-1:0]     w_ph_inc;
    logic [TIME_W-1:0]      w_el;
    logic                   w_load;
    logic                   w_walk_more;

    // ids beyond the bank change nothing
    assign w_id_ext = ID_EXT_W'(i_timer_id);
    assign w_id     = w_id_ext[IDX_W-1:0];
    assign w_id_ok  = ({1'b0, w_id_ext} < (ID_EXT_W+1)'(TIMER_COUNT));

    // shared decrementer for the tick walk
    assign w_dec = w_rd.rem - COUNT_WIDTH'(1);

    assign w_up_inc    = r_uptime + TIME_W'(1);
    assign w_ph_inc    = r_phase + PHASE_W'(1);
    assign w_walk_more = (r_idx < WALK_W'(TIMER_COUNT));

    // elapsed with wrap: all-ones minus last is its complement
    assign w_el = (r_uptime >= r_last) ? (r_uptime - r_last) : (~r_last + r_uptime);

    assign w_load = (r_state == ST_DONE) && (!r_out_vld || !i_stall);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_last    = r_last;
        n_cid     = r_cid;
        n_id_ok   = r_id_ok;
        n_exp     = r_exp;
        n_hs      = r_hs;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_widx    = r_widx;
        n_uptime  = r_uptime;
        n_phase   = r_phase;
        w_wr      = '0;
        w_rd_en   = 1'b0;
        w_rd_addr = w_id;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op    = i_operation;
                    n_last  = i_last_time;
                    n_cid   = w_id;
                    n_id_ok = w_id_ok;
                    n_exp   = 1'b0;
                    n_hs    = 1'b0;
                    n_state = ST_DONE;
                    w_wr.addr = w_id;
                    case (i_operation)
                        OP_TICK: begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = ST_WALK;
                        end
                        OP_ONCE, OP_AUTO: begin
                            // load counter and period, clear flag, set mode
                            w_wr.we_rem  = w_id_ok;
                            w_wr.rem     = i_period[COUNT_WIDTH-1:0];
                            w_wr.we_rel  = w_id_ok;
                            w_wr.rel     = i_period[COUNT_WIDTH-1:0];
                            w_wr.we_flag = w_id_ok;
                            w_wr.flag    = 1'b0;
                            w_wr.we_mode = w_id_ok;
                            w_wr.mode    = (i_operation == OP_AUTO);
                        end
                        OP_STOP: begin
                            // period is kept
                            w_wr.we_rem  = w_id_ok;
                            w_wr.rem     = '0;
                            w_wr.we_flag = w_id_ok;
                            w_wr.flag    = 1'b0;
                            w_wr.we_mode = w_id_ok;
                            w_wr.mode    = 1'b0;
                        end
                        OP_CHECK: begin
                            w_rd_en = 1'b1;
                            n_state = ST_CHECK;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                // return the flag and clear it
                w_wr.addr = r_cid;
                if (r_id_ok && w_rd.flag) begin
                    n_exp        = 1'b1;
                    w_wr.we_flag = 1'b1;
                    w_wr.flag    = 1'b0;
                end
                n_state = ST_DONE;
            end
            ST_WALK: begin
                // issue the next read while writing back the previous entry
                if (w_walk_more) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + WALK_W'(1);
                    n_widx    = r_idx[IDX_W-1:0];
                end
                n_pend    = w_walk_more;
                w_wr.addr = r_widx;
                if (r_pend && (w_rd.rem != '0)) begin
                    w_wr.we_rem = 1'b1;
                    if (w_dec == '0) begin
                        // expiry: flag it, reload in auto mode
                        w_wr.rem     = w_rd.mode ? w_rd.rel : '0;
                        w_wr.we_flag = 1'b1;
                        w_wr.flag    = 1'b1;
                    end else begin
                        w_wr.rem = w_dec;
                    end
                end
                if (!w_walk_more && !r_pend) begin
                    n_uptime = (w_up_inc == UPTIME_WRAP) ? '0 : w_up_inc;
                    if (w_ph_inc >= STROBE_EVERY) begin
                        n_phase = '0;
                        n_hs    = 1'b1;
                    end else begin
                        n_phase = w_ph_inc;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_uptime  <= '0;
            r_phase   <= '0;
            r_out_vld <= 1'b0;
            r_exp     <= 1'b0;
            r_hs      <= 1'b0;
            r_id_ok   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_uptime  <= n_uptime;
            r_phase   <= n_phase;
            r_out_vld <= n_out_vld;
            r_exp     <= n_exp;
            r_hs      <= n_hs;
            r_id_ok   <= n_id_ok;
        end
    end

    // transaction payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_last <= n_last;
        r_cid  <= n_cid;
        r_widx <= n_widx;
        if (w_load) begin
            r_o_exp <= r_exp;
            r_o_run <= r_uptime;
            r_o_el  <= (r_op == OP_ELAPSED) ? w_el : '0;
            r_o_hs  <= r_hs;
        end
    end

    stb_bank u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd      (w_rd)
    );

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_vld;
    assign o_expired     = r_o_exp;
    assign o_run_time    = r_o_run;
    assign o_elapsed     = r_o_el;
    assign o_half_second = r_o_hs;

`ifndef ASSERT_OFF
    // the run-time counter skips the all-ones value
    a_uptime_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_uptime != UPTIME_WRAP)
        else $error("run-time counter reached wrap value");

    // strobe phase stays below the strobe period
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < STROBE_EVERY)
        else $error("tick phase out of range");

    // the walk never runs past the bank
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= WALK_W'(TIMER_COUNT))
        else $error("tick walk index past bank");

    // a new result only comes out of the done state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside done state");

    // the bank is written only while a transaction is in flight
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.we_rem || w_wr.we_flag) |-> (r_state != ST_DONE))
        else $error("bank written in done state");
`endif

endmodule

[tb/sv/tb_soft_timer_bank.sv]
`timescale 1ns / 1ps

module tb_soft_timer_bank;
    import stb_pkg::*;

    // one result transaction
    typedef struct packed {
        logic              expired;
        logic [TIME_W-1:0] run_time;
        logic [TIME_W-1:0] elapsed;
        logic              half_second;
    } t_timer_result;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [TIME_W-1:0] STAMP_MAX = UPTIME_WRAP - 1'b1;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic [OP_W-1:0]     i_operation = '0;
    logic [ID_W-1:0]     i_timer_id  = '0;
    logic [PERIOD_W-1:0] i_period    = '0;
    logic [TIME_W-1:0]   i_last_time = '0;
    logic                i_stall     = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                o_expired;
    logic [TIME_W-1:0]   o_run_time;
    logic [TIME_W-1:0]   o_elapsed;
    logic                o_half_second;

    // predicted timer bank
    logic [COUNT_WIDTH-1:0] count_left [TIMER_COUNT];
    logic [COUNT_WIDTH-1:0] reload_period [TIMER_COUNT];
    logic                   expiry_flag [TIMER_COUNT];
    logic                   auto_reload [TIMER_COUNT];
    logic [TIME_W-1:0]      uptime_ticks;
    logic [PHASE_W-1:0]     strobe_phase;

    t_timer_result outcome_q[$];
    int            error_count;
    int            result_count;
    int            gap_pct;
    int            stall_pct;
    int            hold_cycles;

    soft_timer_bank dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_timer_id    (i_timer_id),
        .i_period      (i_period),
        .i_last_time   (i_last_time),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_expired     (o_expired),
        .o_run_time    (o_run_time),
        .o_elapsed     (o_elapsed),
        .o_half_second (o_half_second)
    );

    always begin
        #4;
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
    end

    // bank state after reset
    task automatic clear_bank_model();
        for (int i = 0; i < TIMER_COUNT; i++) begin
            count_left[i]    = '0;
            reload_period[i] = '0;
            expiry_flag[i]   = 1'b0;
            auto_reload[i]   = 1'b0;
        end
        uptime_ticks = '0;
        strobe_phase = '0;
    endtask

    // applies one request to the predicted bank and returns its result
    function automatic t_timer_result predict_timer(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                                    logic [PERIOD_W-1:0] period,
                                                    logic [TIME_W-1:0] stamp);
        t_timer_result res;
        res = '0;
        case (op)
            OP_TICK: begin
                for (int i = 0; i < TIMER_COUNT; i++) begin
                    if (count_left[i] != '0) begin
                        count_left[i] = count_left[i] - 1'b1;
                        if (count_left[i] == '0) begin
                            expiry_flag[i] = 1'b1;
                            if (auto_reload[i])
                                count_left[i] = reload_period[i];
                        end
                    end
                end
                uptime_ticks = uptime_ticks + 1'b1;
                if (uptime_ticks == UPTIME_WRAP)
                    uptime_ticks = '0;
                strobe_phase = strobe_phase + 1'b1;
                if (strobe_phase >= STROBE_EVERY) begin
                    strobe_phase    = '0;
                    res.half_second = 1'b1;
                end
            end
            OP_ONCE, OP_AUTO: begin
                count_left[id]    = period[COUNT_WIDTH-1:0];
                reload_period[id] = period[COUNT_WIDTH-1:0];
                expiry_flag[id]   = 1'b0;
                auto_reload[id]   = (op == OP_AUTO);
            end
            OP_STOP: begin
                count_left[id]  = '0;
                expiry_flag[id] = 1'b0;
                auto_reload[id] = 1'b0;
            end
            OP_CHECK: begin
                res.expired     = expiry_flag[id];
                expiry_flag[id] = 1'b0;
            end
            OP_ELAPSED: begin
                if (uptime_ticks >= stamp)
                    res.elapsed = uptime_ticks - stamp;
                else
                    res.elapsed = UPTIME_WRAP - stamp + uptime_ticks;
            end
            default: ;
        endcase
        res.run_time = uptime_ticks;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch on result %0d: %s", $realtime, result_count, what);
        error_count++;
    endtask

    task automatic set_idling(input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    // offers one request transaction and records its predicted result on acceptance
    task automatic send_txn(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [PERIOD_W-1:0] period,
                            input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_timer_id  <= id;
        i_period    <= period;
        i_last_time <= stamp;
        do @(posedge i_clk); while (o_stall);
        outcome_q.push_back(predict_timer(op, id, period, stamp));
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        // run-time read and elapsed, plain and wrapped
        send_txn(OP_READ_TIME, 3'd0, '0, '0);
        send_txn(OP_ELAPSED, 3'd0, '0, '0);
        send_txn(OP_ELAPSED, 3'd7, '1, UPTIME_WRAP);
        send_txn(OP_ELAPSED, 3'd2, '0, STAMP_MAX);
        send_txn(OP_UNUSED, 3'd5, '1, '1);
        // one-shot, auto, zero period, largest period, reload every tick
        send_txn(OP_ONCE, 3'd0, 32'd1, '0);
        send_txn(OP_AUTO, 3'd7, 32'd2, '0);
        send_txn(OP_ONCE, 3'd3, '0, '0);
        send_txn(OP_AUTO, 3'd5, '1, '0);
        send_txn(OP_AUTO, 3'd1, 32'd1, '0);
        send_txn(OP_TICK, 3'd0, '0, '0);
        // flag is returned once, then cleared
        send_txn(OP_CHECK, 3'd0, '0, '0);
        send_txn(OP_CHECK, 3'd0, '0, '0);
        send_txn(OP_CHECK, 3'd3, '0, '0);
        send_txn(OP_CHECK, 3'd1, '0, '0);
        send_txn(OP_TICK, 3'd0, '0, '0);
        send_txn(OP_CHECK, 3'd7, '0, '0);
        // stop keeps the period but clears count and flag
        send_txn(OP_STOP, 3'd5, '0, '0);
        send_txn(OP_CHECK, 3'd5, '0, '0);
        // fifth tick raises the strobe
        send_txn(OP_TICK, 3'd0, '0, '0);
        send_txn(OP_TICK, 3'd0, '0, '0);
        send_txn(OP_TICK, 3'd0, '0, '0);
        send_txn(OP_CHECK, 3'd7, '0, '0);
        send_txn(OP_CHECK, 3'd1, '0, '0);
        send_txn(OP_ELAPSED, 3'd0, '0, 31'd2);
    endtask

    // random traffic weighted toward ticks and checks so timers keep expiring
    task automatic run_random(input int count);
        logic [OP_W-1:0]     op;
        int                  pick;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   stamp;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 30)      op = OP_TICK;
            else if (pick < 42) op = OP_ONCE;
            else if (pick < 54) op = OP_AUTO;
            else if (pick < 60) op = OP_STOP;
            else if (pick < 85) op = OP_CHECK;
            else if (pick < 90) op = OP_READ_TIME;
            else                op = OP_ELAPSED;
            id   = ID_W'($urandom_range(TIMER_COUNT - 1));
            pick = $urandom_range(9);
            if (pick < 7)       period = $urandom_range(12, 1);
            else if (pick == 7) period = '0;
            else                period = $urandom();
            // stamps near the run-time, or anywhere so the wrap path is hit
            if ($urandom_range(1))
                stamp = TIME_W'(uptime_ticks - $urandom_range(8));
            else
                stamp = TIME_W'($urandom_range(STAMP_MAX));
            if (stamp == UPTIME_WRAP)
                stamp = '0;
            send_txn(op, id, period, stamp);
        end
    endtask

    task automatic test_random_phases();
        set_idling(0, 0);
        run_random(85);
        set_idling(56, 0);
        run_random(85);
        set_idling(0, 56);
        run_random(85);
        set_idling(20, 20);
        run_random(85);
    endtask

    // receiver holds off long enough that the block backs up into o_stall
    task automatic test_result_holdoff();
        set_idling(0, 0);
        hold_cycles = 150;
        run_random(20);
    endtask

    // sender pauses with work in flight until the bank has answered everything
    task automatic test_drain_pause();
        set_idling(0, 30);
        run_random(15);
        wait_drained();
        run_random(15);
    endtask

    // receiver side: long hold-off when requested, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker: every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = outcome_q.pop_front();
                if (o_expired !== want.expired)
                    report_mismatch($sformatf("expired got %0b want %0b",
                                              o_expired, want.expired));
                if (o_run_time !== want.run_time)
                    report_mismatch($sformatf("run_time got %0d want %0d",
                                              o_run_time, want.run_time));
                if (o_elapsed !== want.elapsed)
                    report_mismatch($sformatf("elapsed got %0d want %0d",
                                              o_elapsed, want.elapsed));
                if (o_half_second !== want.half_second)
                    report_mismatch($sformatf("half_second got %0b want %0b",
                                              o_half_second, want.half_second));
            end
            result_count++;
        end
    end

    // watchdog: too long without any transaction on either channel
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        error_count  = 0;
        result_count = 0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_cycles  = 0;
        clear_bank_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phases();
        test_result_holdoff();
        test_drain_pause();

        wait_drained();
        repeat (TIMER_COUNT + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/stb_pkg.sv
hw/rtl/stb_bank.sv
hw/rtl/soft_timer_bank.sv
tb/sv/tb_soft_timer_bank.sv
